// ===== rtl/core/neighbor_distance_table_top_defines.svh =====
// ---------------------------------------------------------------------------
// neighbor distance table assertion macros
// shared concurrent assertion forms for the table rtl
// ---------------------------------------------------------------------------
`ifndef NEIGHBOR_DISTANCE_TABLE_TOP_DEFINES_SVH
`define NEIGHBOR_DISTANCE_TABLE_TOP_DEFINES_SVH

// property that holds at every edge outside reset
`define NDT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication outside reset
`define NDT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/ndt_pkg.sv =====
// ---------------------------------------------------------------------------
// ndt_pkg
// types and constants shared by the neighbor distance table modules
// ---------------------------------------------------------------------------
`default_nettype none

package ndt_pkg;

  localparam int OP_W        = 3;
  localparam int ID_W        = 32;
  localparam int DIST_W      = 16;
  localparam int SLOT_W      = 4;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_MERGE  = 3'd0,
    OP_SET    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_READ   = 3'd4,
    OP_CLEAR  = 3'd5
  } ndt_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_UPDATE,
    ST_SHIFT,
    ST_SLOT,
    ST_FINISH
  } ndt_state_t;

  typedef struct packed {
    logic load_in;
    logic scan_start;
    logic scan_step;
    logic commit;
    logic shift_start;
    logic shift_step;
    logic count_dec;
    logic read_slot;
    logic res_from_q;
    logic res_clear;
    logic clear_count;
    logic out_load;
  } ndt_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            hit;
    logic            scan_done;
    logic            shift_done;
    logic            slot_ok;
    logic            out_busy;
  } ndt_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ndt_ctrl.sv =====
// ---------------------------------------------------------------------------
// ndt_ctrl
// sequencer for the neighbor distance table: accept, then read, clear or scan, update, shift
// ---------------------------------------------------------------------------
`default_nettype none

module ndt_ctrl
  import ndt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  ndt_stat_t stat,
  output ndt_cmd_t  cmd
);

  ndt_state_t state;
  ndt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (stat.op)
          OP_MERGE, OP_SET, OP_REMOVE, OP_LOOKUP: state_next = ST_SCAN;
          OP_READ:  state_next = stat.slot_ok ? ST_SLOT : ST_FINISH;
          default:  state_next = ST_FINISH;
        endcase
      end
      ST_SCAN: begin
        if (stat.scan_done) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (stat.op == OP_REMOVE && stat.hit) state_next = ST_SHIFT;
        else state_next = ST_FINISH;
      end
      ST_SHIFT: begin
        if (stat.shift_done) state_next = ST_FINISH;
      end
      ST_SLOT: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_DISPATCH: begin
        unique case (stat.op)
          OP_MERGE, OP_SET, OP_REMOVE, OP_LOOKUP: cmd.scan_start = 1'b1;
          OP_READ: begin
            cmd.read_slot = stat.slot_ok;
            cmd.res_clear = !stat.slot_ok;
          end
          OP_CLEAR: begin
            cmd.clear_count = 1'b1;
            cmd.res_clear   = 1'b1;
          end
          default: cmd.res_clear = 1'b1;
        endcase
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_UPDATE: begin
        cmd.commit      = 1'b1;
        cmd.shift_start = (stat.op == OP_REMOVE) && stat.hit;
      end
      ST_SHIFT: begin
        cmd.shift_step = 1'b1;
        cmd.count_dec  = stat.shift_done;
      end
      ST_SLOT: begin
        cmd.res_from_q = 1'b1;
      end
      ST_FINISH: begin
        cmd.out_load = !stat.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/ndt_dp.sv =====
// ---------------------------------------------------------------------------
// ndt_dp
// table storage, scan compare, worst-distance tracking, remove shift and result register
// ---------------------------------------------------------------------------
`default_nettype none

`include "neighbor_distance_table_top_defines.svh"

module ndt_dp
  import ndt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ndt_cmd_t               cmd,
  output ndt_stat_t              stat,
  input  logic [OP_W-1:0]        opcode,
  input  logic [ID_W-1:0]        neighbor_id,
  input  logic [DIST_W-1:0]      measured_distance,
  input  logic [SLOT_W-1:0]      slot_index,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   found,
  output logic [ID_W-1:0]        result_id,
  output logic [DIST_W-1:0]      result_distance,
  output logic [COUNT_OUT_W-1:0] entry_count
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [ID_W-1:0]   ids   [TABLE_DEPTH];
  logic [DIST_W-1:0] dists [TABLE_DEPTH];

  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   id_r;
  logic [DIST_W-1:0] dist_r;
  logic [SLOT_W-1:0] slot_r;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  ptr;
  logic [CNT_W-1:0]  cmp_idx;
  logic              cmp_valid;
  logic              hit;
  logic [CNT_W-1:0]  hit_pos;
  logic [DIST_W-1:0] hit_dist;
  logic [CNT_W-1:0]  worst_pos;
  logic [DIST_W-1:0] worst_dist;

  logic [ID_W-1:0]   id_q;
  logic [DIST_W-1:0] dist_q;

  logic              res_found;
  logic [ID_W-1:0]   res_id;
  logic [DIST_W-1:0] res_dist;

  logic                    ptr_lt;
  logic                    cmp_hit;
  logic                    room;
  logic                    is_upd;
  logic [DIST_W:0]         avg_sum;
  logic [DIST_W-1:0]       upd_dist;
  logic [CNT_W-1:0]        cmp_prev;
  logic [CNT_W-1:0]        ins_pos;
  logic [CNT_W+SLOT_W-1:0] slot_ext;
  logic [CNT_W+SLOT_W-1:0] count_ext;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_wide;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ID_W-1:0]   wr_id;
  logic [DIST_W-1:0] wr_dist;

  assign ptr_lt    = ptr < count;
  assign cmp_hit   = cmp_valid && (id_q == id_r);
  assign room      = count < CNT_W'(TABLE_DEPTH);
  assign is_upd    = (op_r == OP_MERGE) || (op_r == OP_SET);
  assign avg_sum   = {1'b0, hit_dist} + {1'b0, dist_r};
  assign upd_dist  = !hit ? dist_r : ((op_r == OP_MERGE) ? avg_sum[DIST_W:1] : dist_r);
  assign cmp_prev  = cmp_idx - CNT_W'(1);
  assign ins_pos   = hit ? hit_pos : (room ? count : worst_pos);
  assign slot_ext  = {{CNT_W{1'b0}}, slot_r};
  assign count_ext = {{SLOT_W{1'b0}}, count};
  assign cnt_wide  = {{COUNT_OUT_W{1'b0}}, count};

  assign stat.op         = op_r;
  assign stat.hit        = hit;
  assign stat.scan_done  = hit || (!cmp_valid && !ptr_lt);
  assign stat.shift_done = !cmp_valid && !ptr_lt;
  assign stat.slot_ok    = slot_ext < count_ext;
  assign stat.out_busy   = out_valid && out_stall;

  // one read and one write port on the table
  always_comb begin
    rd_en   = cmd.read_slot || ((cmd.scan_step || cmd.shift_step) && ptr_lt);
    rd_addr = cmd.read_slot ? slot_ext[IDX_W-1:0] : ptr[IDX_W-1:0];
    if (cmd.commit) begin
      wr_en   = is_upd;
      wr_addr = ins_pos[IDX_W-1:0];
      wr_id   = id_r;
      wr_dist = upd_dist;
    end else begin
      wr_en   = cmd.shift_step && cmp_valid;
      wr_addr = cmp_prev[IDX_W-1:0];
      wr_id   = id_q;
      wr_dist = dist_q;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ids[wr_addr]   <= wr_id;
      dists[wr_addr] <= wr_dist;
    end
    if (rd_en) begin
      id_q   <= ids[rd_addr];
      dist_q <= dists[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= opcode;
      id_r   <= neighbor_id;
      dist_r <= measured_distance;
      slot_r <= slot_index;
    end
    if (cmd.scan_step && cmp_valid && !hit) begin
      if (cmp_hit) begin
        hit_pos  <= cmp_idx;
        hit_dist <= dist_q;
      end
      if (dist_q > worst_dist) begin
        worst_pos  <= cmp_idx;
        worst_dist <= dist_q;
      end
    end
    if (cmd.scan_start) begin
      worst_pos  <= '0;
      worst_dist <= '0;
    end
    if (cmd.res_clear) begin
      res_found <= 1'b0;
      res_id    <= '0;
      res_dist  <= '0;
    end else if (cmd.res_from_q) begin
      res_found <= 1'b1;
      res_id    <= id_q;
      res_dist  <= dist_q;
    end else if (cmd.commit) begin
      if (is_upd) begin
        res_found <= hit;
        res_id    <= id_r;
        res_dist  <= upd_dist;
      end else begin
        res_found <= hit;
        res_id    <= hit ? id_r : '0;
        res_dist  <= hit ? hit_dist : '0;
      end
    end
    if (cmd.out_load) begin
      found           <= res_found;
      result_id       <= res_id;
      result_distance <= res_dist;
      entry_count     <= cnt_wide[COUNT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ptr       <= '0;
      cmp_idx   <= '0;
      cmp_valid <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        ptr       <= '0;
        cmp_valid <= 1'b0;
        hit       <= 1'b0;
      end else if (cmd.shift_start) begin
        ptr       <= hit_pos + CNT_W'(1);
        cmp_valid <= 1'b0;
      end else if (cmd.scan_step || cmd.shift_step) begin
        if (ptr_lt) ptr <= ptr + CNT_W'(1);
        cmp_valid <= ptr_lt;
        cmp_idx   <= ptr;
        if (cmd.scan_step && cmp_hit && !hit) hit <= 1'b1;
      end
      if (cmd.clear_count) begin
        count <= '0;
      end else if (cmd.count_dec) begin
        count <= count - CNT_W'(1);
      end else if (cmd.commit && is_upd && !hit && room) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `NDT_ASSERT(a_count_max, clk, rst, count <= CNT_W'(TABLE_DEPTH), "count above table depth")
  `NDT_ASSERT_IMP(a_shift_range, clk, rst, cmd.shift_step && cmp_valid,
                  (cmp_idx < count) && (cmp_idx != '0), "shift outside valid entries")
  `NDT_ASSERT_IMP(a_out_free, clk, rst, cmd.out_load, !(out_valid && out_stall),
                  "result loaded over a stalled transfer")

endmodule

`default_nettype wire

// ===== rtl/core/neighbor_distance_table_top.sv =====
// merge, set, lookup and remove scan the table from accept to result (a hit ends the
//   scan early); a remove hit then shifts each later entry down by one
// read at index reads one slot (none past count); clear and unused codes skip the table
// one item at a time: the next transfer is taken the cycle after the result is loaded,
//   bounded by the table scan, on one read port, of up to TABLE_DEPTH entries
// reset empties the table at once (count to zero); no clearing pass
// ---------------------------------------------------------------------------
// neighbor_distance_table_top
// bounded table of neighbor ids and distances with merge, set, remove, lookup
// ---------------------------------------------------------------------------
`default_nettype none

module neighbor_distance_table_top
  import ndt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [OP_W-1:0]        opcode,
  input  logic [ID_W-1:0]        neighbor_id,
  input  logic [DIST_W-1:0]      measured_distance,
  input  logic [SLOT_W-1:0]      slot_index,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   found,
  output logic [ID_W-1:0]        result_id,
  output logic [DIST_W-1:0]      result_distance,
  output logic [COUNT_OUT_W-1:0] entry_count
);

  ndt_cmd_t  cmd;
  ndt_stat_t stat;

  ndt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ndt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .opcode            (opcode),
    .neighbor_id       (neighbor_id),
    .measured_distance (measured_distance),
    .slot_index        (slot_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .found             (found),
    .result_id         (result_id),
    .result_distance   (result_distance),
    .entry_count       (entry_count)
  );

endmodule

`default_nettype wire

// ===== sim/ndt_table_checker.sv =====
// ---------------------------------------------------------------------------
// ndt_table_checker
// watches both channels of the neighbor distance table, keeps its own copy of
// the table to predict each result, and counts mismatches against the block
// ---------------------------------------------------------------------------
`default_nettype none

module ndt_table_checker
  import ndt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [OP_W-1:0]        opcode,
  input  logic [ID_W-1:0]        neighbor_id,
  input  logic [DIST_W-1:0]      measured_distance,
  input  logic [SLOT_W-1:0]      slot_index,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   found,
  input  logic [ID_W-1:0]        result_id,
  input  logic [DIST_W-1:0]      result_distance,
  input  logic [COUNT_OUT_W-1:0] entry_count,
  output int                     fail_count,
  output int                     pending,
  output int                     checked,
  output int                     full_replacements
);

  typedef struct packed {
    logic                   found;
    logic [ID_W-1:0]        id;
    logic [DIST_W-1:0]      distance;
    logic [COUNT_OUT_W-1:0] count;
  } table_result_t;

  logic [ID_W-1:0]   table_ids   [TABLE_DEPTH];
  logic [DIST_W-1:0] table_dists [TABLE_DEPTH];
  int                table_count;
  table_result_t     expected_results [$];
  table_result_t     oldest;

  task automatic report_field(input string field, input logic [ID_W-1:0] want,
                              input logic [ID_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  task automatic predict_table_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                  input logic [DIST_W-1:0] distance,
                                  input logic [SLOT_W-1:0] slot);
    table_result_t r;
    int            pos;
    int            worst;
    int            i;
    logic [DIST_W:0] sum;
    r = '0;
    pos = -1;
    for (i = 0; i < table_count; i++)
      if (pos < 0 && table_ids[i] == id) pos = i;
    case (op)
      OP_MERGE, OP_SET: begin
        if (pos >= 0) begin
          if (op == OP_MERGE) begin
            sum = table_dists[pos] + distance;
            table_dists[pos] = sum[DIST_W:1];
          end else begin
            table_dists[pos] = distance;
          end
          r.found = 1'b1;
          r.distance = table_dists[pos];
        end else begin
          if (table_count < TABLE_DEPTH) begin
            table_ids[table_count] = id;
            table_dists[table_count] = distance;
            table_count++;
          end else begin
            // full table: first entry holding the greatest distance is replaced
            worst = 0;
            for (i = 1; i < TABLE_DEPTH; i++)
              if (table_dists[worst] < table_dists[i]) worst = i;
            table_ids[worst] = id;
            table_dists[worst] = distance;
            full_replacements++;
          end
          r.distance = distance;
        end
        r.id = id;
      end
      OP_REMOVE: begin
        if (pos >= 0) begin
          r.found = 1'b1;
          r.id = id;
          r.distance = table_dists[pos];
          for (i = pos; i + 1 < table_count; i++) begin
            table_ids[i] = table_ids[i+1];
            table_dists[i] = table_dists[i+1];
          end
          table_count--;
        end
      end
      OP_LOOKUP: begin
        if (pos >= 0) begin
          r.found = 1'b1;
          r.id = id;
          r.distance = table_dists[pos];
        end
      end
      OP_READ: begin
        if (slot < table_count) begin
          r.found = 1'b1;
          r.id = table_ids[slot];
          r.distance = table_dists[slot];
        end
      end
      OP_CLEAR: table_count = 0;
      default: ;
    endcase
    r.count = COUNT_OUT_W'(table_count);
    expected_results.push_back(r);
  endtask

  // sampled mid-cycle, so a transfer seen here happens at the next rising edge
  always @(negedge clk) begin
    if (rst) begin
      table_count = 0;
      expected_results.delete();
      fail_count = 0;
      checked = 0;
      full_replacements = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result transfer, expected none, actual found %0d id %0h",
                   $time, found, result_id);
          $display("%0t:   actual distance %0h count %0d",
                   $time, result_distance, entry_count);
        end else begin
          oldest = expected_results.pop_front();
          report_field("found", oldest.found, found);
          report_field("result_id", oldest.id, result_id);
          report_field("result_distance", oldest.distance, result_distance);
          report_field("entry_count", oldest.count, entry_count);
          checked++;
        end
      end
      if (in_valid && !in_stall)
        predict_table_op(opcode, neighbor_id, measured_distance, slot_index);
    end
    pending = expected_results.size();
  end

endmodule

`default_nettype wire

// ===== sim/tb_neighbor_distance_table_top.sv =====
// ---------------------------------------------------------------------------
// tb_neighbor_distance_table_top
// drives directed and random table operations into the neighbor distance
// table under varying sender and receiver idling; a checker beside the block
// predicts every result and the verdict comes from its pending and mismatch count
// ---------------------------------------------------------------------------
`default_nettype none

module tb_neighbor_distance_table_top;
  import ndt_pkg::*;

  localparam int             TABLE_DEPTH = 16;
  localparam int             POOL_SIZE   = 20;
  localparam int             LONG_HOLD   = 200;
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic [OP_W-1:0]        opcode;
  logic [ID_W-1:0]        neighbor_id;
  logic [DIST_W-1:0]      measured_distance;
  logic [SLOT_W-1:0]      slot_index;
  logic                   out_valid;
  logic                   out_stall;
  logic                   found;
  logic [ID_W-1:0]        result_id;
  logic [DIST_W-1:0]      result_distance;
  logic [COUNT_OUT_W-1:0] entry_count;

  int fail_count;
  int pending;
  int checked;
  int full_replacements;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int holds_done;
  int items_sent;

  logic [ID_W-1:0] id_pool [POOL_SIZE];

  neighbor_distance_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .neighbor_id      (neighbor_id),
    .measured_distance(measured_distance),
    .slot_index       (slot_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .found            (found),
    .result_id        (result_id),
    .result_distance  (result_distance),
    .entry_count      (entry_count)
  );

  ndt_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .neighbor_id      (neighbor_id),
    .measured_distance(measured_distance),
    .slot_index       (slot_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .found            (found),
    .result_id        (result_id),
    .result_distance  (result_distance),
    .entry_count      (entry_count),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked),
    .full_replacements(full_replacements)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  // receiver: random stall, or a long hold when one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [DIST_W-1:0] distance, input logic [SLOT_W-1:0] slot);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    neighbor_id <= id;
    measured_distance <= distance;
    slot_index <= slot;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic run_directed();
    int k;
    send_item(OP_READ, '0, '0, '0);
    send_item(OP_LOOKUP, '0, '0, '0);
    send_item(OP_REMOVE, '1, '0, '0);
    send_item(OP_SPARE_A, $urandom, 16'($urandom), 4'($urandom));
    send_item(OP_SPARE_B, $urandom, 16'($urandom), 4'($urandom));
    send_item(OP_SET, '0, '0, '0);
    send_item(OP_SET, '1, '1, '0);
    send_item(OP_MERGE, '1, '1, '0);
    send_item(OP_MERGE, '0, '1, '0);
    send_item(OP_MERGE, '0, '0, '0);
    send_item(OP_LOOKUP, '1, '0, '0);
    send_item(OP_READ, '0, '0, 4'd1);
    send_item(OP_REMOVE, '0, '0, '0);
    send_item(OP_CLEAR, '1, '1, '1);
    // fill with a tie for the greatest distance, then insert into the full table
    for (k = 0; k < TABLE_DEPTH; k++)
      send_item(OP_SET, 32'h1000 + k, (k == 3 || k == 9) ? 16'hF000 : 16'(k * 100), '0);
    send_item(OP_SET, 32'hBEEF, 16'd1, '0);
    send_item(OP_LOOKUP, 32'h1003, '0, '0);
    send_item(OP_READ, '0, '0, 4'd15);
    send_item(OP_REMOVE, 32'h1000, '0, '0);
  endtask

  task automatic send_random_item();
    int                pick;
    int                dsel;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] distance;
    pick = $urandom_range(99);
    if (pick < 25) op = OP_MERGE;
    else if (pick < 45) op = OP_SET;
    else if (pick < 57) op = OP_REMOVE;
    else if (pick < 75) op = OP_LOOKUP;
    else if (pick < 93) op = OP_READ;
    else if (pick < 94) op = OP_CLEAR;
    else if (pick < 97) op = OP_SPARE_A;
    else op = OP_SPARE_B;
    id = ($urandom_range(9) == 0) ? ID_W'($urandom) : id_pool[$urandom_range(POOL_SIZE-1)];
    dsel = $urandom_range(9);
    if (dsel == 0) distance = '0;
    else if (dsel == 1) distance = '1;
    else if (dsel == 2) distance = 16'($urandom_range(15));
    else distance = 16'($urandom);
    send_item(op, id, distance, 4'($urandom));
  endtask

  task automatic run_random(input int count);
    int n;
    for (n = 0; n < count; n++) send_random_item();
  endtask

  initial begin
    int i;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = '0;
    neighbor_id = '0;
    measured_distance = '0;
    slot_index = '0;
    hold_requests = 0;
    holds_done = 0;
    items_sent = 0;
    send_idle_pct = 21;
    recv_idle_pct = 73;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_random(400);
    drain();

    send_idle_pct = 73;
    recv_idle_pct = 21;
    run_random(400);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    run_random(400);
    drain();

    repeat (40) @(posedge clk);
    $display("covered %0d transfers in and %0d results checked", items_sent, checked);
    $display("%0d inserts hit a full table, one long output hold", full_replacements);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/ndt_pkg.sv
rtl/core/ndt_ctrl.sv
rtl/core/ndt_dp.sv
rtl/core/neighbor_distance_table_top.sv
sim/ndt_table_checker.sv
sim/tb_neighbor_distance_table_top.sv
